>>> design/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg
// shared codes, widths and types of the two-button mode selector
// ----------------------------------------------------------------------------
package dms_pkg;

  localparam int TIME_BITS_DEFAULT = 16;
  localparam int NOW_W             = 16;
  localparam int DBNC_W            = 8;
  localparam int EVENT_W           = 2;
  localparam int MODE_W            = 2;
  localparam int LANES             = 2;

  localparam logic [DBNC_W-1:0] DBNC_INIT = 8'd10;

  localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_RISING  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_FALLING = 2'd2;

  localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CROSS    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM      = 2'd2;

  // lane index of each button
  localparam int LANE_STRAIGHT = 0;
  localparam int LANE_CROSS    = 1;

  typedef logic [EVENT_W-1:0] event_t;

  typedef struct packed {
    event_t cross_event;
    event_t straight_event;
  } events_t;

  // packed so that the first field lands in the highest bits
  typedef struct packed {
    event_t              cross_event;
    event_t              straight_event;
    logic                ab_relay;
    logic                sum_relay;
    logic                cross_lamp;
    logic                straight_lamp;
    logic                mode_changed;
    logic [MODE_W-1:0]   mode;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int IN_FIELDS_W = 2 + NOW_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

endpackage

>>> design/dms_debounce.sv
// ----------------------------------------------------------------------------
// dms_debounce
// one debounce lane: idle and wait phases with a wrapping start-time timer
// ----------------------------------------------------------------------------
module dms_debounce #(
  parameter int TIME_BITS = dms_pkg::TIME_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        level,
  input  logic [TIME_BITS-1:0]        now,
  input  logic [dms_pkg::DBNC_W-1:0]  debounce_time,
  output dms_pkg::event_t             event_code
);

  logic                 level_q;
  logic                 waiting;
  logic [TIME_BITS-1:0] start;
  logic [TIME_BITS-1:0] elapsed;
  logic                 done;
  logic                 changed;

  assign elapsed = now - start;
  assign done    = elapsed >= TIME_BITS'(debounce_time);
  assign changed = level != level_q;

  always_comb begin
    event_code = dms_pkg::EV_NONE;
    if (waiting && done) begin
      event_code = level ? dms_pkg::EV_RISING : dms_pkg::EV_FALLING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_q <= 1'b0;
      waiting <= 1'b1;
      start   <= '0;
    end else if (step) begin
      level_q <= level;
      if (!waiting) begin
        if (changed) begin
          start   <= now;
          waiting <= 1'b1;
        end
      end else if (done) begin
        waiting <= 1'b0;
      end else if (changed) begin
        start <= now;
      end
    end
  end

endmodule

>>> design/dms_mode_sel.sv
// ----------------------------------------------------------------------------
// dms_mode_sel
// merges the lane events into the mode state, leds and relays
// ----------------------------------------------------------------------------
module dms_mode_sel (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  dms_pkg::events_t  events,
  output dms_pkg::result_t  result
);

  logic [dms_pkg::MODE_W-1:0] mode;
  logic [dms_pkg::MODE_W-1:0] mode_next;
  logic                       ab_held;
  logic                       ab_held_next;
  logic                       s_rel;
  logic                       c_rel;

  assign s_rel = events.straight_event == dms_pkg::EV_FALLING;
  assign c_rel = events.cross_event == dms_pkg::EV_FALLING;

  always_comb begin
    mode_next = mode;
    if (s_rel && !c_rel) begin
      mode_next = (mode == dms_pkg::MODE_CROSS) ? dms_pkg::MODE_SUM : dms_pkg::MODE_CROSS;
    end else if (!s_rel && c_rel) begin
      mode_next = (mode == dms_pkg::MODE_CROSS || mode == dms_pkg::MODE_SUM)
                ? dms_pkg::MODE_STRAIGHT : dms_pkg::MODE_SUM;
    end
  end

  always_comb begin
    ab_held_next = ab_held;
    result       = '0;
    case (mode_next)
      dms_pkg::MODE_CROSS: begin
        result.cross_lamp = 1'b1;
        ab_held_next      = 1'b1;
      end
      dms_pkg::MODE_SUM: begin
        result.straight_lamp = 1'b1;
        result.cross_lamp    = 1'b1;
        result.sum_relay     = 1'b1;
      end
      default: begin
        result.straight_lamp = 1'b1;
        ab_held_next         = 1'b0;
      end
    endcase
    result.mode           = mode_next;
    result.mode_changed   = mode_next != mode;
    result.ab_relay       = ab_held_next;
    result.straight_event = events.straight_event;
    result.cross_event    = events.cross_event;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= dms_pkg::MODE_STRAIGHT;
      ab_held <= 1'b0;
    end else if (step) begin
      mode    <= mode_next;
      ab_held <= ab_held_next;
    end
  end

endmodule

>>> design/debounced_two_button_mode_selector.sv
// ----------------------------------------------------------------------------
// debounced_two_button_mode_selector
// two debounced buttons stepping a straight / cross / sum mode selector
// ----------------------------------------------------------------------------
// Every request carries both raw button levels and a millisecond timestamp and
// yields exactly one result in the following cycle, held in an output register. A
// request is taken every clock while that register is empty or being drained,
// so the block sustains one request per cycle; the per-button debounce lanes
// and the mode merge are combinational ahead of that register. The debounce time
// register is written through the cfg channel, which is always ready, and
// resets to 10 ms.
module debounced_two_button_mode_selector #(
  parameter int TIME_BITS = dms_pkg::TIME_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dms_pkg::DBNC_W-1:0]       cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // straight_level, cross_level, now_ms
  input  logic [dms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // mode, mode_changed, straight lamp, cross lamp, sum_relay, ab_relay,
  // straight_event, cross_event
  output logic [dms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  logic [dms_pkg::DBNC_W-1:0]  debounce_time;
  logic                        step;
  logic [31:0]                 now_wide;
  logic [TIME_BITS-1:0]        now;
  logic [dms_pkg::LANES-1:0]   levels;
  dms_pkg::event_t             lane_event [dms_pkg::LANES];
  dms_pkg::events_t            events;
  dms_pkg::result_t            result;
  dms_pkg::result_t            result_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= dms_pkg::DBNC_INIT;
    end else if (cfg_valid) begin
      debounce_time <= cfg_data;
    end
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign levels        = s_axis_tdata[1:0];
  assign now_wide      = {16'b0, s_axis_tdata[dms_pkg::IN_FIELDS_W-1:2]};
  assign now           = now_wide[TIME_BITS-1:0];

  for (genvar i = 0; i < dms_pkg::LANES; i++) begin : g_lane
    dms_debounce #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk           (clk),
      .rst           (rst),
      .step          (step),
      .level         (levels[i]),
      .now           (now),
      .debounce_time (debounce_time),
      .event_code    (lane_event[i])
    );
  end

  assign events.straight_event = lane_event[dms_pkg::LANE_STRAIGHT];
  assign events.cross_event    = lane_event[dms_pkg::LANE_CROSS];

  dms_mode_sel u_mode_sel (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .events (events),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign m_axis_tdata = dms_pkg::OUT_TDATA_W'(result_q);

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> result_q.mode != 2'd3)
    else $error("mode code three on output");

  a_change_one_release: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result_q.mode_changed) |->
      ((result_q.straight_event == dms_pkg::EV_FALLING) !=
       (result_q.cross_event == dms_pkg::EV_FALLING)))
    else $error("mode changed without a single release");

  a_sum_leds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && result_q.sum_relay) |->
      (result_q.straight_lamp && result_q.cross_lamp &&
       result_q.mode == dms_pkg::MODE_SUM))
    else $error("sum relay outside sum mode");

endmodule
